@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int unsigned NumPagesDef  = 4096;
  localparam int unsigned PageShiftDef = 12;
  localparam int unsigned WordBitsDef  = 32;

  typedef enum logic [1:0] {
    FuncAllocPage  = 2'd0,
    FuncAllocRun   = 2'd1,
    FuncFreePage   = 2'd2,
    FuncFreeRegion = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatNoSpace   = 2'd1,
    StatBelowFlr  = 2'd2,
    StatOutRange  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegBase  = 2'd0,
    RegCount = 2'd1,
    RegFloor = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StRdReq,
    StRdWait,
    StScan,
    StWrite,
    StRelease,
    StRelWait,
    StRelWrite,
    StClaimRd,
    StClaimWait,
    StClaimWrite,
    StDone
  } back_st_e;

  // classified request between front and back
  typedef struct packed {
    logic [1:0]  func;
    logic        bad;       // status decided at the front
    logic [1:0]  bad_stat;
    logic [31:0] first;     // first page
    logic [32:0] npages;    // page count of run or region
  } req_t;

endpackage

@@ rtl/bpa_if.sv @@
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] byte_addr;
  logic [31:0] byte_length;
  modport source (output valid, func, byte_addr, byte_length, input ready);
  modport sink (input valid, func, byte_addr, byte_length, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] alloc_addr;
  logic [1:0]  status;
  logic [12:0] free_pages;
  modport source (output valid, alloc_addr, status, free_pages, input ready);
  modport sink (input valid, alloc_addr, status, free_pages, output ready);
endinterface

@@ rtl/bitmap_page_allocator_unit.sv @@
// bitmap page allocator: one free bit per page, next-fit cursor, free count
// req channel: func, byte_addr, byte_length; rsp channel: alloc_addr,
// status, free_pages, one beat per request in request order
// a front stage classifies requests (floor check, page math) into a
// two-entry queue; the back stage walks the bitmap ram one page per cycle
// between word fetches; a rejected request goes from check straight to
// done; a free reads each bitmap word it touches, sets its bits page by
// page and writes the word back; an allocation scans from the cursor,
// reloading at each word, then claims pages the same way as a free
// throughput: one request at a time, the next starts once the previous
// rsp beat has left
// registers over apb: 0 region_base_page, 1 region_page_count,
// 2 free_floor_addr; write only while no request is in flight
// reset: every page used, cursor and count zero, registers zero; no
// clearing pass, words never written read as all used
// a stalled rsp holds its beat; the queue keeps accepting up to two requests
module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int unsigned NumPages  = bpa_pkg::NumPagesDef,
  parameter int unsigned PageShift = bpa_pkg::PageShiftDef,
  parameter int unsigned WordBits  = bpa_pkg::WordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpa_req_if.sink     req,
  bpa_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [11:0] base_q;
  logic [12:0] count_q;
  logic [31:0] floor_q;
  logic        q_valid, q_pop;
  req_t        q_data;
  reg_e        ridx;

  assign pready = 1'b1;
  assign ridx = reg_e'(paddr[3:2]);

  always_comb begin
    unique case (ridx)
      RegBase:  prdata = {20'd0, base_q};
      RegCount: prdata = {19'd0, count_q};
      RegFloor: prdata = floor_q;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; count_q <= '0; floor_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        RegBase:  base_q <= pwdata[11:0];
        RegCount: count_q <= pwdata[12:0];
        RegFloor: floor_q <= pwdata;
        default: ;
      endcase
    end
  end

  bpa_front #(.PageShift(PageShift)) u_front (
    .clk_i, .rst_ni, .req, .floor_i(floor_q),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  bpa_back #(.NumPages(NumPages), .PageShift(PageShift), .WordBits(WordBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .base_i(base_q), .count_i(count_q), .rsp
  );
endmodule

@@ rtl/bpa_ram.sv @@
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/bpa_front.sv @@
module bpa_front #(
  parameter int unsigned PageShift = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpa_req_if.sink       req,
  input  logic [31:0]   floor_i,
  output logic          q_valid_o,
  output bpa_pkg::req_t q_data_o,
  input  logic          q_pop_i
);
  import bpa_pkg::*;

  localparam int unsigned Depth = 2;

  req_t        fifo_q [Depth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  req_t        cls;
  logic [31:0] first;
  logic [32:0] endb;
  logic        push;

  always_comb begin
    first = {{PageShift{1'b0}}, req.byte_addr[31:PageShift]};
    cls = '0;
    endb = '0;
    cls.func  = req.func;
    cls.first = first;
    unique case (func_e'(req.func))
      FuncAllocPage: cls.npages = 33'd1;
      FuncAllocRun: begin
        endb = {1'b0, req.byte_length} + 33'((64'd1 << PageShift) - 64'd1);
        cls.npages = 33'(endb >> PageShift);
      end
      FuncFreePage: cls.npages = 33'd1;
      default: begin
        endb = {1'b0, req.byte_addr[31:PageShift], {PageShift{1'b0}}}
             + {1'b0, req.byte_length} - 33'd1;
        // last page minus first page plus one
        cls.npages = 33'(endb >> PageShift) - {1'b0, first} + 33'd1;
      end
    endcase
    if (req.func[1]) begin
      if ({req.byte_addr[31:PageShift], {PageShift{1'b0}}} < floor_i) begin
        cls.bad = 1'b1; cls.bad_stat = StatBelowFlr;
      end else if (func_e'(req.func) == FuncFreeRegion && req.byte_length == '0) begin
        cls.bad = 1'b1; cls.bad_stat = StatOutRange;
      end
    end
  end

  assign req.ready = (cnt_q != 2'(Depth));
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

@@ rtl/bpa_back.sv @@
module bpa_back #(
  parameter int unsigned NumPages  = 4096,
  parameter int unsigned PageShift = 12,
  parameter int unsigned WordBits  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  bpa_pkg::req_t q_data_i,
  output logic          q_pop_o,
  input  logic [11:0]   base_i,
  input  logic [12:0]   count_i,
  bpa_rsp_if.source     rsp
);
  import bpa_pkg::*;

  localparam int unsigned Words = (NumPages + WordBits - 1) / WordBits;
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW = $clog2(WordBits);
  localparam int unsigned PW = $clog2(NumPages + 1);
  localparam int unsigned CW = PW;

  back_st_e st_q, st_d;
  req_t     r_q;

  logic [PW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] fcnt_q, fcnt_d;
  logic [Words-1:0] wr_q, wr_d;   // word has been written since reset
  logic [PW-1:0] p_q, p_d;        // current page
  logic [PW-1:0] cand_q, cand_d;  // run candidate start
  logic [PW:0]   run_q, run_d;    // free pages found at candidate
  logic [PW:0]   it_q, it_d;      // scan position count
  logic [32:0]   left_q, left_d;
  logic [PW-1:0] start_q, start_d;

  logic [31:0]   out_addr_q, out_addr_d;
  logic [1:0]    out_stat_q, out_stat_d;
  logic          ovalid_q, ovalid_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WordBits-1:0] wdata, rdata, word_q, word_d, cur_word;

  logic [PW-1:0] base, rend, cnt;
  logic [PW:0]   sum;

  always_comb begin
    sum  = (PW+1)'(base_i) + (PW+1)'(count_i);
    base = PW'(base_i);
    if (sum > (PW+1)'(NumPages)) rend = PW'(NumPages);
    else rend = PW'(sum);
    if (rend < base) rend = base;
    cnt = rend - base;
  end

  bpa_ram #(.Width(WordBits), .Depth(Words)) u_map (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [AW-1:0] pw;
  logic [BW-1:0] pb;
  logic          bit_v, last_bit;
  logic [PW-1:0] p_next;

  assign pw = AW'(p_q / WordBits);
  assign pb = BW'(p_q % WordBits);
  assign cur_word = wr_q[pw] ? rdata : '0;

  always_comb begin
    st_d = st_q; cursor_d = cursor_q; fcnt_d = fcnt_q; wr_d = wr_q;
    p_d = p_q; cand_d = cand_q; run_d = run_q; it_d = it_q; left_d = left_q;
    start_d = start_q; word_d = word_q; out_addr_d = out_addr_q;
    out_stat_d = out_stat_q; ovalid_d = ovalid_q;
    we = 1'b0; waddr = pw; wdata = word_q; raddr = pw;
    q_pop_o = 1'b0;
    bit_v = word_q[pb];
    last_bit = (pb == BW'(WordBits - 1));
    p_next = p_q + 1'b1;
    if (ovalid_q && rsp.ready) ovalid_d = 1'b0;
    unique case (st_q)
      // the next request starts only once the previous beat has left
      StIdle: if (q_valid_i && (!ovalid_q || rsp.ready)) begin
        q_pop_o = 1'b1;
        st_d = StCheck;
      end
      StCheck: begin
        out_addr_d = '0; out_stat_d = StatOk;
        if (r_q.bad) begin
          out_stat_d = r_q.bad_stat; st_d = StDone;
        end else if (r_q.func[1]) begin
          if (r_q.first + r_q.npages - 33'd1 >= 33'(NumPages)
              || r_q.first >= 32'(NumPages)) begin
            out_stat_d = StatOutRange; st_d = StDone;
          end else begin
            p_d = PW'(r_q.first); left_d = r_q.npages;
            cursor_d = PW'(r_q.first);
            st_d = StRelease;
          end
        end else begin
          if (r_q.npages == '0 || fcnt_q == '0 || r_q.npages > 33'(fcnt_q)
              || cnt == '0 || r_q.npages > 33'(cnt)) begin
            out_stat_d = StatNoSpace; st_d = StDone;
          end else begin
            start_d = (cursor_q < base || cursor_q >= rend) ? base : cursor_q;
            p_d = (cursor_q < base || cursor_q >= rend) ? base : cursor_q;
            cand_d = p_d; run_d = '0; it_d = '0;
            st_d = StRdReq;
          end
        end
      end
      StRdReq: st_d = StRdWait;
      StRdWait: begin word_d = cur_word; st_d = StScan; end
      StScan: begin
        // one page per cycle, reloading the word at boundaries and wrap
        if (it_q >= (PW+1)'(cnt)) begin
          out_stat_d = StatNoSpace; st_d = StDone;
        end else if (run_q == '0 && 33'(cand_q) + r_q.npages > 33'(rend)) begin
          // candidate cannot fit before end, skip it
          it_d = it_q + 1'b1;
          p_d = (p_next >= rend) ? base : p_next;
          cand_d = p_d;
          if (p_next >= rend || last_bit) st_d = StRdReq;
        end else if (bit_v) begin
          run_d = run_q + 1'b1;
          if (33'(run_q) + 33'd1 == r_q.npages) begin
            p_d = cand_q; left_d = r_q.npages;
            out_addr_d = 32'(64'(cand_q) << PageShift);
            fcnt_d = (33'(fcnt_q) > r_q.npages) ? CW'(33'(fcnt_q) - r_q.npages) : '0;
            cursor_d = (33'(cand_q) + r_q.npages >= 33'(rend)) ? base
                     : PW'(33'(cand_q) + r_q.npages);
            st_d = StClaimRd;
          end else begin
            p_d = p_next;
            if (last_bit) st_d = StRdReq;
          end
        end else begin
          it_d = it_q + run_q + 1'b1;
          run_d = '0;
          p_d = (p_next >= rend) ? base : p_next;
          cand_d = p_d;
          if (p_next >= rend || last_bit) st_d = StRdReq;
        end
      end
      StClaimRd: st_d = StClaimWait;
      StClaimWait: begin word_d = cur_word; st_d = StClaimWrite; end
      StClaimWrite: begin
        word_d[pb] = 1'b0;
        left_d = left_q - 33'd1;
        p_d = p_next;
        if (left_q == 33'd1 || last_bit) begin
          we = 1'b1; wdata = word_d; wr_d[pw] = 1'b1;
          st_d = (left_q == 33'd1) ? StDone : StClaimRd;
        end
      end
      StRelease: st_d = StRelWait;
      StRelWait: begin word_d = cur_word; st_d = StRelWrite; end
      StRelWrite: begin
        if (!word_q[pb]) begin
          word_d[pb] = 1'b1;
          if (fcnt_q < CW'(NumPages)) fcnt_d = fcnt_q + 1'b1;
        end
        left_d = left_q - 33'd1;
        p_d = p_next;
        if (left_q == 33'd1 || last_bit) begin
          we = 1'b1; wdata = word_d; wr_d[pw] = 1'b1;
          st_d = (left_q == 33'd1) ? StDone : StRelease;
        end
      end
      StDone: if (!ovalid_q || rsp.ready) begin
        ovalid_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  assign rsp.valid      = ovalid_q;
  assign rsp.alloc_addr = out_addr_q;
  assign rsp.status     = out_stat_q;
  assign rsp.free_pages = 13'(fcnt_q);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) r_q <= q_data_i;
    p_q <= p_d; cand_q <= cand_d; run_q <= run_d; it_q <= it_d;
    left_q <= left_d; start_q <= start_d; word_q <= word_d;
    out_addr_q <= out_addr_d; out_stat_q <= out_stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cursor_q <= '0; fcnt_q <= '0; wr_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; cursor_q <= cursor_d; fcnt_q <= fcnt_d; wr_q <= wr_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
